@@ sv/bal_pkg.sv @@
// Shared types, codes and defaults for the banked array allocator.
`timescale 1ns / 1ps
package bal_pkg;

   localparam int BANK_BYTES_DEF   = 8192;
   localparam int HANDLE_COUNT_DEF = 256;
   localparam int DESC_BANK_DEF    = 1;
   localparam int DESC_SHIFT_DEF   = 3;
   localparam int WINDOW_BASE_DEF  = 40960;

   localparam logic [1:0] OP_ALLOC     = 2'd0;
   localparam logic [1:0] OP_TRANSLATE = 2'd1;
   localparam logic [1:0] OP_QUERY     = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BOUNDS    = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EXHAUSTED = 3'd4;

   localparam logic [7:0] LAST_BANK = 8'd255;

   typedef struct packed {
      logic [1:0]         operation;
      logic [7:0]         handle;
      logic signed [15:0] index;
      logic [13:0]        count;
      logic [13:0]        elem_size;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  new_handle;
      logic [7:0]  bank;
      logic [15:0] address;
      logic [13:0] copy_bytes;
      logic        exists;
   } rsp_type;

   // One descriptor: the offset is kept as a 16-bit window address.
   typedef struct packed {
      logic [7:0]  bank;
      logic [15:0] offset;
      logic [15:0] count;
      logic [13:0] size;
      logic [3:0]  shift;
   } desc_type;

   // Smallest shift whose power of two covers the element size.
   function automatic logic [3:0] size_shift(input logic [13:0] esz);
      logic [13:0] m;
      logic [3:0]  sh;
      m  = esz - 14'd1;
      sh = 4'd0;
      if (esz != 14'd0) begin
         for (int i = 0; i < 14; i++) begin
            if (m[i]) begin
               sh = 4'(i + 1);
            end
         end
      end
      return sh;
   endfunction

endpackage

@@ sv/bal_desc_mem.sv @@
// Descriptor table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module bal_desc_mem
   import bal_pkg::*;
#(
   parameter int DEPTH = HANDLE_COUNT_DEF,
   parameter int AW    = $clog2(HANDLE_COUNT_DEF)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output desc_type      rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  desc_type      wr_data
);

   desc_type mem [DEPTH];
   desc_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bal_exec.sv @@
// Execute stage: allocator state, descriptor select, bounds check, result register.
`timescale 1ns / 1ps
module bal_exec
   import bal_pkg::*;
#(
   parameter int BANK_BYTES   = BANK_BYTES_DEF,
   parameter int HANDLE_COUNT = HANDLE_COUNT_DEF,
   parameter int DESC_BANK    = DESC_BANK_DEF,
   parameter int DESC_SHIFT   = DESC_SHIFT_DEF,
   parameter int WINDOW_BASE  = WINDOW_BASE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid,
   input  req_type                           req,
   input  logic [3:0]                        shift,
   input  desc_type                          rd_data,
   output logic                              wr_en,
   output logic [$clog2(HANDLE_COUNT)-1:0]   wr_addr,
   output desc_type                          wr_data,
   output logic                              rsp_strobe,
   output rsp_type                           rsp_payload
);

   localparam int HIDX_W = $clog2(HANDLE_COUNT);
   localparam int NH_W   = $clog2(HANDLE_COUNT + 1);
   localparam int OFF_W  = $clog2(BANK_BYTES + 1);
   localparam int CMP_W  = (NH_W > 8) ? NH_W : 8;
   localparam int TOT_W  = 28;

   localparam desc_type DESC0 = '{
      bank:   8'(DESC_BANK),
      offset: 16'(WINDOW_BASE),
      count:  16'(BANK_BYTES >> DESC_SHIFT),
      size:   14'(1 << DESC_SHIFT),
      shift:  4'(DESC_SHIFT)
   };

   logic [NH_W-1:0]  nh_ff, nh_in;
   logic [7:0]       bank_ff, bank_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic             byp_valid_ff;
   logic [NH_W-1:0]  byp_addr_ff;
   desc_type         byp_data_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [CMP_W-1:0] handle_x;
   logic             handle_live;
   desc_type         entry;
   logic             idx_ok;
   logic [15:0]      elem_off;

   logic [TOT_W-1:0] total;
   logic [OFF_W-1:0] room;
   logic             too_large, table_full, need_new, exhausted, alloc_ok;
   logic [7:0]       use_bank;
   logic [OFF_W-1:0] use_off;
   logic [15:0]      use_addr;

   // Pick the descriptor: fixed entry zero, last-cycle write, or memory.
   always_comb begin
      handle_x    = CMP_W'(req.handle);
      handle_live = handle_x < CMP_W'(nh_ff);
      if (req.handle == 8'd0) begin
         entry = DESC0;
      end else if (byp_valid_ff && (CMP_W'(byp_addr_ff) == handle_x)) begin
         entry = byp_data_ff;
      end else begin
         entry = rd_data;
      end
      idx_ok   = handle_live && !req.index[15]
                 && (16'(req.index[14:0]) < entry.count);
      elem_off = 16'(req.index[14:0]) << entry.shift;
   end

   always_comb begin
      total      = TOT_W'(req.count) << shift;
      too_large  = total > TOT_W'(BANK_BYTES);
      table_full = nh_ff >= NH_W'(HANDLE_COUNT);
      room       = OFF_W'(BANK_BYTES) - off_ff;
      need_new   = TOT_W'(room) < total;
      exhausted  = need_new && (bank_ff == LAST_BANK);
      alloc_ok   = !too_large && !table_full && !exhausted;
      use_bank   = need_new ? bank_ff + 8'd1 : bank_ff;
      use_off    = need_new ? '0 : off_ff;
      use_addr   = 16'(WINDOW_BASE) + 16'(use_off);
   end

   always_comb begin
      nh_in   = nh_ff;
      bank_in = bank_ff;
      off_in  = off_ff;
      wr_en   = 1'b0;
      wr_addr = HIDX_W'(nh_ff);
      wr_data = '{
         bank:   use_bank,
         offset: use_addr,
         count:  16'(req.count),
         size:   req.elem_size,
         shift:  shift
      };
      rsp_in  = '0;
      case (req.operation)
         OP_ALLOC: begin
            if (too_large) begin
               rsp_in.status = ST_TOO_LARGE;
            end else if (table_full) begin
               rsp_in.status = ST_FULL;
            end else if (exhausted) begin
               rsp_in.status = ST_EXHAUSTED;
            end else begin
               rsp_in.new_handle = 8'(nh_ff);
               rsp_in.bank       = use_bank;
               rsp_in.address    = use_addr;
               rsp_in.copy_bytes = req.elem_size;
            end
            if (valid && alloc_ok) begin
               wr_en   = 1'b1;
               nh_in   = nh_ff + NH_W'(1);
               bank_in = use_bank;
               off_in  = use_off + OFF_W'(total);
            end
         end
         OP_TRANSLATE: begin
            if (idx_ok) begin
               rsp_in.bank       = entry.bank;
               rsp_in.address    = entry.offset + elem_off;
               rsp_in.copy_bytes = entry.size;
               rsp_in.exists     = 1'b1;
            end else begin
               rsp_in.status = ST_BOUNDS;
            end
         end
         OP_QUERY: begin
            rsp_in.exists = idx_ok;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nh_ff        <= NH_W'(1);
         bank_ff      <= 8'(DESC_BANK + 1);
         off_ff       <= '0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nh_ff        <= nh_in;
         bank_ff      <= bank_in;
         off_ff       <= off_in;
         byp_valid_ff <= wr_en;
         rsp_valid_ff <= valid;
      end
   end

   // Hold the last write so a read issued in the same cycle still sees it.
   always_ff @(posedge clock) begin
      byp_addr_ff <= nh_ff;
      byp_data_ff <= wr_data;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ sv/banked_array_allocator.sv @@
// Top level of the banked array allocator: request register, table memory, execute stage.
`timescale 1ns / 1ps
// A new transaction is taken in every cycle; busy is tied low, so start may be
// held high back to back. Each transaction yields exactly one result, shown on
// rsp_payload with rsp_strobe high for one cycle. Taking a transaction loads
// the request register and starts the registered read of the descriptor
// memory; the execute stage then loads the result register, and the strobe
// rises with it. The result is accepted while the strobe is high. The
// receiver cannot stall, so results are never held. After reset the table
// is usable at once: entries are tracked by the handle fill count, so there
// is no clearing pass.
module banked_array_allocator
   import bal_pkg::*;
#(
   parameter int BANK_BYTES   = BANK_BYTES_DEF,
   parameter int HANDLE_COUNT = HANDLE_COUNT_DEF,
   parameter int DESC_BANK    = DESC_BANK_DEF,
   parameter int DESC_SHIFT   = DESC_SHIFT_DEF,
   parameter int WINDOW_BASE  = WINDOW_BASE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int HIDX_W = $clog2(HANDLE_COUNT);

   logic              accept;
   logic              req_valid_ff;
   req_type           req_ff;
   logic [3:0]        shift_ff;
   desc_type          rd_data;
   logic              wr_en;
   logic [HIDX_W-1:0] wr_addr;
   desc_type          wr_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_payload;
         shift_ff <= size_shift(req_payload.elem_size);
      end
   end

   bal_desc_mem #(
      .DEPTH (HANDLE_COUNT),
      .AW    (HIDX_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (HIDX_W'(req_payload.handle)),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bal_exec #(
      .BANK_BYTES   (BANK_BYTES),
      .HANDLE_COUNT (HANDLE_COUNT),
      .DESC_BANK    (DESC_BANK),
      .DESC_SHIFT   (DESC_SHIFT),
      .WINDOW_BASE  (WINDOW_BASE)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .valid       (req_valid_ff),
      .req         (req_ff),
      .shift       (shift_ff),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sim/tb_banked_array_allocator.sv @@
// Testbench for the banked array allocator: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module tb_banked_array_allocator;
   import bal_pkg::*;

   localparam int unsigned BANK        = BANK_BYTES_DEF;
   localparam int unsigned HANDLES     = HANDLE_COUNT_DEF;
   localparam int unsigned RAND_ITEMS  = 1550;
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam logic [1:0]  OP_UNDEF    = 2'd3;

   typedef struct {
      int unsigned bank;
      int unsigned offset;
      int unsigned count;
      int unsigned size;
      int unsigned shift;
   } array_desc_type;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   array_desc_type descs [HANDLES];
   int unsigned    next_hdl;
   int unsigned    cur_bank;
   int unsigned    cur_off;
   rsp_type        owed_rsps [$];
   stim_row_type   dir_rows [$];
   int unsigned    mismatches = 0;
   int unsigned    cycles = 0;
   int unsigned    burst_left = 0;

   banked_array_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_type mk_req(input logic [1:0] op, input int unsigned hdl,
                                      input int idx, input int unsigned cnt,
                                      input int unsigned esz);
      req_type r;
      r.operation = op;
      r.handle    = 8'(hdl);
      r.index     = 16'(idx);
      r.count     = 14'(cnt);
      r.elem_size = 14'(esz);
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [2:0] st, input int unsigned hdl,
                                      input int unsigned bnk, input int unsigned addr,
                                      input int unsigned bytes, input bit ex);
      rsp_type o;
      o.status     = st;
      o.new_handle = 8'(hdl);
      o.bank       = 8'(bnk);
      o.address    = 16'(addr);
      o.copy_bytes = 14'(bytes);
      o.exists     = ex;
      return o;
   endfunction

   // Power-of-two exponent that covers the element size; zero rounds to one byte.
   function automatic int unsigned round_shift(input int unsigned esz);
      int unsigned sh;
      sh = 0;
      while ((32'd1 << sh) < esz) sh++;
      return sh;
   endfunction

   // Advance the allocator state by one transaction and return its result.
   function automatic rsp_type allocator_step(input req_type r);
      rsp_type        o;
      int unsigned    sh;
      int unsigned    total;
      int unsigned    bnk;
      int unsigned    off;
      int             ix;
      bit             in_range;
      array_desc_type d;
      o = '0;
      if (r.operation == OP_ALLOC) begin
         sh    = round_shift(r.elem_size);
         total = 32'(r.count) << sh;
         bnk   = cur_bank;
         off   = cur_off;
         if (total > BANK) begin
            o.status = ST_TOO_LARGE;
         end else if (next_hdl >= HANDLES) begin
            o.status = ST_FULL;
         end else if (BANK - off < total && bnk >= LAST_BANK) begin
            o.status = ST_EXHAUSTED;
         end else begin
            if (BANK - off < total) begin
               bnk++;
               off = 0;
            end
            descs[next_hdl] = '{bnk, WINDOW_BASE_DEF + off, r.count, r.elem_size, sh};
            cur_bank     = bnk;
            cur_off      = off + total;
            o.new_handle = 8'(next_hdl);
            o.bank       = 8'(bnk);
            o.address    = 16'(WINDOW_BASE_DEF + off);
            o.copy_bytes = r.elem_size;
            next_hdl++;
         end
      end else if (r.operation == OP_TRANSLATE || r.operation == OP_QUERY) begin
         d        = descs[r.handle];
         ix       = r.index;
         in_range = ix >= 0 && ix < int'(d.count);
         if (r.operation == OP_QUERY) begin
            o.exists = in_range;
         end else if (!in_range) begin
            o.status = ST_BOUNDS;
         end else begin
            o.bank       = 8'(d.bank);
            o.address    = 16'(d.offset + (32'(ix) << d.shift));
            o.copy_bytes = 14'(d.size);
            o.exists     = 1'b1;
         end
      end
      return o;
   endfunction

   // Random transaction shaped by the current allocator state: large allocations
   // step through the banks so both exhaustion and a full table are reached.
   function automatic req_type make_item();
      req_type     r;
      int unsigned pick;
      int unsigned sh;
      int unsigned cnt;
      r.operation = OP_UNDEF;
      r.handle    = 8'($urandom);
      r.index     = 16'($urandom);
      r.count     = 14'($urandom);
      r.elem_size = 14'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         r.operation = OP_ALLOC;
         if (next_hdl < HANDLES) begin
            sh = $urandom_range(0, 13);
            r.elem_size = (sh == 0) ? 14'($urandom_range(0, 1))
                                    : 14'($urandom_range((1 << (sh - 1)) + 1, 1 << sh));
            if (cur_bank < LAST_BANK || $urandom_range(0, 1) == 0) begin
               r.count = 14'($urandom_range(((BANK / 2) >> sh) + 1, BANK >> sh));
            end else begin
               // pack into what is left of the last bank
               r.count = 14'($urandom_range(0, (BANK - cur_off) >> sh));
            end
         end
      end else if (pick < 28) begin
         r.operation = OP_ALLOC;
         if (next_hdl < HANDLES) begin
            // keep these oversized so they never take a handle
            sh = round_shift(r.elem_size);
            r.count = 14'($urandom_range((BANK >> sh) + 1, 16383));
         end
      end else if (pick < 96) begin
         r.operation = (pick < 62) ? OP_TRANSLATE : OP_QUERY;
         if ($urandom_range(0, 4) != 0) begin
            r.handle = 8'($urandom_range(0, next_hdl - 1));
         end
         cnt  = descs[r.handle].count;
         pick = $urandom_range(0, 99);
         if (pick < 70 && cnt != 0) begin
            r.index = 16'($urandom_range(0, cnt - 1));
         end else if (pick < 85) begin
            case ($urandom_range(0, 3))
               0: r.index = 16'(cnt);
               1: r.index = 16'(cnt - 1);
               2: r.index = 16'hFFFF;
               default: r.index = 16'h8000;
            endcase
         end
      end
      return r;
   endfunction

   // Hold start through a burst, then drop it for a random gap.
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 20);
      end
   endtask

   task automatic send(input req_type r, input bit typed, input rsp_type want);
      rsp_type model;
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy !== 1'b0);
      model = allocator_step(r);
      owed_rsps.push_back(typed ? want : model);
      pace();
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      rsp_type got;
      string   diff;
      if (!reset && rsp_strobe === 1'b1) begin
         got = rsp_payload;
         if (owed_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: got %p", got);
         end else begin
            want = owed_rsps.pop_front();
            diff = "";
            if (got.status !== want.status) diff = {diff, " status"};
            if (got.new_handle !== want.new_handle) diff = {diff, " new_handle"};
            if (got.bank !== want.bank) diff = {diff, " bank"};
            if (got.address !== want.address) diff = {diff, " address"};
            if (got.copy_bytes !== want.copy_bytes) diff = {diff, " copy_bytes"};
            if (got.exists !== want.exists) diff = {diff, " exists"};
            if (diff != "") begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch in%s: expected %p, got %p", diff, want, got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_type     item;
      int unsigned n;
      foreach (descs[i]) descs[i] = '{0, 0, 0, 0, 0};
      descs[0] = '{DESC_BANK_DEF, WINDOW_BASE_DEF, BANK_BYTES_DEF >> DESC_SHIFT_DEF,
                   1 << DESC_SHIFT_DEF, DESC_SHIFT_DEF};
      next_hdl = 1;
      cur_bank = DESC_BANK_DEF + 1;
      cur_off  = 0;

      // descriptor of the table itself, bounds, allocations, oversized requests and undefined operations
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 0, 0, 0, 0), 1'b1,
                           mk_rsp(ST_OK, 0, 1, 40960, 8, 1'b1)});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 0, 1023, 16383, 16383), 1'b1,
                           mk_rsp(ST_OK, 0, 1, 49144, 8, 1'b1)});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 0, 1024, 0, 0), 1'b1,
                           mk_rsp(ST_BOUNDS, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 0, -1, 0, 0), 1'b1,
                           mk_rsp(ST_BOUNDS, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 0, -32768, 0, 0), 1'b1,
                           mk_rsp(ST_BOUNDS, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_QUERY, 0, -32768, 0, 0), 1'b1,
                           mk_rsp(ST_OK, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_QUERY, 0, 1023, 0, 0), 1'b1,
                           mk_rsp(ST_OK, 0, 0, 0, 0, 1'b1)});
      dir_rows.push_back('{mk_req(OP_QUERY, 255, 0, 0, 0), 1'b1,
                           mk_rsp(ST_OK, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 1, 0, 0, 0), 1'b1,
                           mk_rsp(ST_BOUNDS, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 255, 32767, 0, 0), 1'b1,
                           mk_rsp(ST_BOUNDS, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_ALLOC, 255, 32767, 3, 5), 1'b1,
                           mk_rsp(ST_OK, 1, 2, 40960, 5, 1'b0)});
      dir_rows.push_back('{mk_req(OP_ALLOC, 0, 0, 16383, 0), 1'b1,
                           mk_rsp(ST_TOO_LARGE, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_ALLOC, 0, 0, 2, 8192), 1'b1,
                           mk_rsp(ST_TOO_LARGE, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_ALLOC, 255, -1, 16383, 16383), 1'b1,
                           mk_rsp(ST_TOO_LARGE, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_ALLOC, 0, 0, 1, 8192), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 1, 2, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 1, 3, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_TRANSLATE, 2, 0, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_QUERY, 2, 1, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_QUERY, 1, 2, 0, 0), 1'b0, '0});
      dir_rows.push_back('{mk_req(OP_UNDEF, 255, -1, 16383, 16383), 1'b1,
                           mk_rsp(ST_OK, 0, 0, 0, 0, 1'b0)});
      dir_rows.push_back('{mk_req(OP_UNDEF, 0, 0, 0, 0), 1'b1,
                           mk_rsp(ST_OK, 0, 0, 0, 0, 1'b0)});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 2 && owed_rsps.size() != 0) begin
            // drain every outstanding transaction before going on
            start <= 1'b0;
            while (owed_rsps.size() != 0) @(posedge clock);
         end
         item = make_item();
         send(item, 1'b0, '0);
      end

      start <= 1'b0;
      while (owed_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ banked_array_allocator.f @@
sv/bal_pkg.sv
sv/bal_desc_mem.sv
sv/bal_exec.sv
sv/banked_array_allocator.sv
sim/tb_banked_array_allocator.sv
